>>> rtl/aahs_pkg.sv
// shared types and constants of the arm authorization handshake unit
// result word layout, result groups, register map and message codes
// no dependencies
`default_nettype none

package aahs_pkg;

  // message codes carried on the input op field
  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_COUNT = 2'd1,
    OP_ITEM  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_CMD_ACK     = 3'd0,
    KIND_LIST_REQ    = 3'd1,
    KIND_ITEM_REQ    = 3'd2,
    KIND_MISSION_ACK = 3'd3,
    KIND_HEARTBEAT   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ACK_IN_PROGRESS = 2'd0,
    ACK_ACCEPTED    = 2'd1,
    ACK_DENIED      = 2'd2,
    ACK_FAILED      = 2'd3
  } ack_t;

  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_BAD_ITEM = 2'd1,
    REASON_TIMEOUT  = 2'd2
  } reason_t;

  // register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_CMD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ALT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTH_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRANT_SEC    = 3'd5;

  typedef struct packed {
    logic        [7:0]  own_system_id;
    logic        [15:0] arm_command_code;
    logic signed [31:0] max_altitude_mm;
    logic        [31:0] auth_timeout_ticks;
    logic        [31:0] heartbeat_period_ticks;
    logic        [15:0] grant_seconds;
  } cfg_t;

  // one result word without the last flag
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  dest_system;
    ack_t        ack_result;
    reason_t     deny_reason;
    logic [15:0] ack_param;
    logic [15:0] request_seq;
  } res_t;

  // all results caused by one input word, slot 0 first
  localparam int unsigned GRP_SLOTS = 3;
  typedef struct packed {
    logic [1:0]                cnt;
    res_t [GRP_SLOTS-1:0]      res;
  } grp_t;

  // group queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

>>> rtl/aahs_if.sv
// channel interfaces of the arm authorization handshake unit
// input message channel, result channel, register write channel
// depends on aahs_pkg
`default_nettype none

interface aahs_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic        [7:0]  sender_system;
  logic        [7:0]  addressed_system;
  logic        [15:0] command_code;
  logic        [15:0] item_count;
  logic        [15:0] item_seq;
  logic signed [31:0] altitude_mm;

  modport source (
    output valid, op, sender_system, addressed_system, command_code,
           item_count, item_seq, altitude_mm,
    input  ready
  );
  modport sink (
    input  valid, op, sender_system, addressed_system, command_code,
           item_count, item_seq, altitude_mm,
    output ready
  );
endinterface

interface aahs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  dest_system;
  logic [1:0]  ack_result;
  logic [1:0]  deny_reason;
  logic [15:0] ack_param;
  logic [15:0] request_seq;
  logic        last;

  modport source (
    output valid, kind, dest_system, ack_result, deny_reason, ack_param,
           request_seq, last,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_system, ack_result, deny_reason, ack_param,
           request_seq, last,
    output ready
  );
endinterface

interface aahs_cfg_if;
  import aahs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/aahs_front.sv
// front part: accepts input words, runs the handshake state machine and
// builds the group of results each word causes
// depends on aahs_pkg and aahs_if
`default_nettype none

module aahs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  aahs_in_if.sink            in_ch,
  input  wire aahs_pkg::cfg_t cfg,
  input  wire logic          q_full,
  output logic               push,
  output aahs_pkg::grp_t     push_grp
);
  import aahs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_COUNT = 2'd1,
    PH_ITEMS = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  peer_r, peer_nxt;
  logic [15:0] expected_r, expected_nxt;
  logic        mission_ok_r, mission_ok_nxt;
  logic [15:0] first_bad_r, first_bad_nxt;
  logic [31:0] auth_cnt_r, auth_cnt_nxt;
  logic [31:0] hb_cnt_r, hb_cnt_nxt;

  logic        accept;
  logic        for_us;
  logic        bad_item;
  logic [15:0] next_seq;
  logic [1:0]  slot;
  grp_t        grp;

  function automatic res_t mk_res(kind_t k, logic [7:0] dest, ack_t a, reason_t r,
                                  logic [15:0] param, logic [15:0] seq);
    res_t w;
    w.kind        = k;
    w.dest_system = dest;
    w.ack_result  = a;
    w.deny_reason = r;
    w.ack_param   = param;
    w.request_seq = seq;
    return w;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign for_us      = (in_ch.addressed_system == cfg.own_system_id);
  assign next_seq    = in_ch.item_seq + 16'd1;
  assign bad_item    = mission_ok_r &&
                       ($signed(in_ch.altitude_mm) > $signed(cfg.max_altitude_mm));

  always_comb begin
    phase_nxt      = phase_r;
    peer_nxt       = peer_r;
    expected_nxt   = expected_r;
    mission_ok_nxt = mission_ok_r;
    first_bad_nxt  = first_bad_r;
    auth_cnt_nxt   = auth_cnt_r;
    hb_cnt_nxt     = hb_cnt_r;
    grp            = '0;
    slot           = 2'd0;
    unique case (op_t'(in_ch.op))
      OP_CMD: begin
        if (in_ch.command_code == cfg.arm_command_code && phase_r == PH_IDLE && for_us) begin
          peer_nxt     = in_ch.sender_system;
          phase_nxt    = PH_COUNT;
          auth_cnt_nxt = cfg.auth_timeout_ticks;
          grp.res[0]   = mk_res(KIND_CMD_ACK, in_ch.sender_system, ACK_IN_PROGRESS,
                                REASON_NONE, 16'd0, 16'd0);
          grp.res[1]   = mk_res(KIND_LIST_REQ, in_ch.sender_system, ACK_IN_PROGRESS,
                                REASON_NONE, 16'd0, 16'd0);
          grp.cnt      = 2'd2;
        end
      end
      OP_COUNT: begin
        if (phase_r == PH_COUNT && for_us) begin
          if (in_ch.item_count == 16'd0) begin
            grp.res[0] = mk_res(KIND_CMD_ACK, peer_r, ACK_DENIED, REASON_BAD_ITEM,
                                16'd0, 16'd0);
            phase_nxt  = PH_IDLE;
          end else begin
            expected_nxt   = in_ch.item_count;
            phase_nxt      = PH_ITEMS;
            mission_ok_nxt = 1'b1;
            grp.res[0]     = mk_res(KIND_ITEM_REQ, peer_r, ACK_IN_PROGRESS, REASON_NONE,
                                    16'd0, 16'd0);
          end
          grp.cnt = 2'd1;
        end
      end
      OP_ITEM: begin
        if (phase_r == PH_ITEMS && for_us) begin
          if (bad_item) begin
            mission_ok_nxt = 1'b0;
            first_bad_nxt  = in_ch.item_seq;
          end
          if (next_seq == expected_r) begin
            if (!bad_item && mission_ok_r) begin
              grp.res[0] = mk_res(KIND_CMD_ACK, peer_r, ACK_ACCEPTED, REASON_NONE,
                                  cfg.grant_seconds, 16'd0);
            end else begin
              grp.res[0] = mk_res(KIND_CMD_ACK, peer_r, ACK_DENIED, REASON_BAD_ITEM,
                                  first_bad_nxt, 16'd0);
            end
            grp.res[1] = mk_res(KIND_MISSION_ACK, peer_r, ACK_IN_PROGRESS, REASON_NONE,
                                16'd0, 16'd0);
            grp.cnt    = 2'd2;
            phase_nxt  = PH_IDLE;
          end else begin
            grp.res[0] = mk_res(KIND_ITEM_REQ, peer_r, ACK_IN_PROGRESS, REASON_NONE,
                                16'd0, next_seq);
            grp.cnt    = 2'd1;
          end
        end
      end
      OP_TICK: begin
        if (hb_cnt_r == 32'd0) begin
          grp.res[slot] = mk_res(KIND_HEARTBEAT, 8'd0, ACK_IN_PROGRESS, REASON_NONE,
                                 16'd0, 16'd0);
          slot          = slot + 2'd1;
          hb_cnt_nxt    = (cfg.heartbeat_period_ticks == 32'd0) ? 32'd0
                          : cfg.heartbeat_period_ticks - 32'd1;
        end else begin
          hb_cnt_nxt = hb_cnt_r - 32'd1;
        end
        if (phase_r != PH_IDLE) begin
          if (auth_cnt_r == 32'd0) begin
            grp.res[slot] = mk_res(KIND_CMD_ACK, peer_r, ACK_FAILED, REASON_TIMEOUT,
                                   16'd0, 16'd0);
            slot          = slot + 2'd1;
            grp.res[slot] = mk_res(KIND_MISSION_ACK, peer_r, ACK_IN_PROGRESS,
                                   REASON_NONE, 16'd0, 16'd0);
            slot          = slot + 2'd1;
            phase_nxt     = PH_IDLE;
          end else begin
            auth_cnt_nxt = auth_cnt_r - 32'd1;
          end
        end
        grp.cnt = slot;
      end
      default: ;
    endcase
  end

  assign push     = accept && (grp.cnt != 2'd0);
  assign push_grp = grp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      peer_r       <= '0;
      expected_r   <= '0;
      mission_ok_r <= 1'b0;
      first_bad_r  <= '0;
      auth_cnt_r   <= '0;
      hb_cnt_r     <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      peer_r       <= peer_nxt;
      expected_r   <= expected_nxt;
      mission_ok_r <= mission_ok_nxt;
      first_bad_r  <= first_bad_nxt;
      auth_cnt_r   <= auth_cnt_nxt;
      hb_cnt_r     <= hb_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aahs_queue.sv
// short queue of result groups between front and back
// head entry is shown without a read delay
// depends on aahs_pkg
`default_nettype none

module aahs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire aahs_pkg::grp_t push_grp,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output aahs_pkg::grp_t      head
);
  import aahs_pkg::*;

  grp_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QAW-1:0] ptr_inc(logic [QAW-1:0] p);
    return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

`default_nettype wire

>>> rtl/aahs_back.sv
// back part: walks the head group one result at a time into the
// output register and marks the final word of each group
// depends on aahs_pkg and aahs_if
`default_nettype none

module aahs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire aahs_pkg::grp_t q_head,
  output logic                pop,
  aahs_out_if.source          out_ch
);
  import aahs_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;
  logic       out_last_r;
  logic       load;
  logic       grp_end;

  assign load    = q_not_empty && (!out_valid_r || out_ch.ready);
  assign grp_end = (idx_r == (q_head.cnt - 2'd1));
  assign pop     = load && grp_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = grp_end ? 2'd0 : idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= q_head.res[idx_r];
      out_last_r <= grp_end;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.dest_system = out_res_r.dest_system;
  assign out_ch.ack_result  = out_res_r.ack_result;
  assign out_ch.deny_reason = out_res_r.deny_reason;
  assign out_ch.ack_param   = out_res_r.ack_param;
  assign out_ch.request_seq = out_res_r.request_seq;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire

>>> rtl/arm_authorization_handshake_unit.sv
// arm authorization handshake unit, top level
// holds the register file and joins front, group queue and back
// depends on aahs_pkg, aahs_if, aahs_front, aahs_queue, aahs_back
//
// in_ch takes decoded words: arm command, mission count, mission item, tick.
// out_ch gives the result words: command ack, list request,
// item request, mission ack or heartbeat; last marks the final word caused
// by one input word (up to three). cfg_ch writes the six registers by index
// and is always ready; write only while no words are in flight.
// an accepted word's group is written into the queue; the back then loads
// its results into the output register, one result word per cycle while
// out_ch is ready. throughput: one input word per cycle while results keep
// pace; the single output register drains one word per ready cycle.
// a two-group queue sits between the state machine and the output side, so
// input keeps flowing while a finished word waits at out_ch.
// a stalled receiver holds out_ch steady; once the queue fills in_ch.ready
// drops. synchronous reset restores register defaults, returns the state
// machine to idle, clears both countdowns (first tick sends a heartbeat) and
// empties the queue.
`default_nettype none

module arm_authorization_handshake_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aahs_in_if.sink    in_ch,
  aahs_out_if.source out_ch,
  aahs_cfg_if.sink   cfg_ch
);
  import aahs_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full;
  logic q_not_empty;
  logic q_push;
  logic q_pop;
  grp_t q_push_grp;
  grp_t q_head;

  // register file, writes always taken
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_OWN_ID:       cfg_nxt.own_system_id          = cfg_ch.data[7:0];
        REG_ARM_CMD:      cfg_nxt.arm_command_code       = cfg_ch.data[15:0];
        REG_MAX_ALT:      cfg_nxt.max_altitude_mm        = $signed(cfg_ch.data);
        REG_AUTH_TIMEOUT: cfg_nxt.auth_timeout_ticks     = cfg_ch.data;
        REG_HB_PERIOD:    cfg_nxt.heartbeat_period_ticks = cfg_ch.data;
        REG_GRANT_SEC:    cfg_nxt.grant_seconds          = cfg_ch.data[15:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_system_id          <= 8'd10;
      cfg_r.arm_command_code       <= 16'd3001;
      cfg_r.max_altitude_mm        <= 32'sd15000;
      cfg_r.auth_timeout_ticks     <= 32'd10000;
      cfg_r.heartbeat_period_ticks <= 32'd3000;
      cfg_r.grant_seconds          <= 16'd60;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: classify and update handshake state
  aahs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (q_push),
    .push_grp (q_push_grp)
  );

  // result groups waiting for the output side
  aahs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_grp  (q_push_grp),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // back: serialize each group onto out_ch
  aahs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/aahs_checker.sv
// port-level checks of the arm authorization handshake unit
// bound to the top level; depends on aahs_pkg
`default_nettype none

module aahs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [7:0]  out_dest_system,
  input wire logic [1:0]  out_ack_result,
  input wire logic [15:0] out_ack_param,
  input wire logic        out_last
);
  import aahs_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_ack_param) && $stable(out_last))
    else $error("result word changed while stalled");

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // in-progress ack is never the last word of its group
  a_progress_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CMD_ACK && out_ack_result == ACK_IN_PROGRESS
      |-> !out_last)
    else $error("in-progress ack marked last");

  // heartbeat goes to nobody and carries no ack
  a_heartbeat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEARTBEAT
      |-> out_dest_system == 8'd0 && out_ack_result == ACK_IN_PROGRESS)
    else $error("heartbeat with payload");

  // mission ack always closes its group
  a_mission_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_MISSION_ACK |-> out_last)
    else $error("mission ack not last");

endmodule

bind arm_authorization_handshake_unit aahs_checker u_aahs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_dest_system (out_ch.dest_system),
  .out_ack_result  (out_ch.ack_result),
  .out_ack_param   (out_ch.ack_param),
  .out_last        (out_ch.last)
);

`default_nettype wire

>>> verif/arm_authorization_handshake_unit_tb.sv
// testbench of the arm authorization handshake unit: directed and random message words
// checked word by word against a local model of the handshake and its registers
// depends on aahs_pkg, aahs_if and arm_authorization_handshake_unit
module arm_authorization_handshake_unit_tb;
  import aahs_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_COUNT, PH_ITEMS} phase_t;
  // how often a side holds off: never, on every word, or now and then
  typedef enum {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;

  typedef struct {
    op_t                op;
    logic        [7:0]  sender;
    logic        [7:0]  target;
    logic        [15:0] code;
    logic        [15:0] count;
    logic        [15:0] seq;
    logic signed [31:0] alt;
  } msg_t;

  typedef struct {
    res_t w;
    logic last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aahs_in_if  in_if();
  aahs_out_if out_if();
  aahs_cfg_if cfg_if();

  arm_authorization_handshake_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // words waiting to be sent, result words waiting to arrive
  msg_t   msg_q[$];
  reply_t reply_q[$];
  int unsigned n_queued = 0;
  int unsigned n_noise  = 0;
  int unsigned n_taken  = 0;
  int unsigned errors   = 0;

  pace_t       in_mode  = PACE_SPARSE;
  pace_t       out_mode = PACE_SPARSE;
  int unsigned in_gap    = 0;
  int unsigned out_stall = 0;
  logic        in_fired  = 1'b0;
  logic        out_fired = 1'b0;

  // register shadow
  logic        [7:0]  own_id;
  logic        [15:0] arm_code;
  logic signed [31:0] alt_limit;
  logic        [31:0] auth_ticks;
  logic        [31:0] hb_ticks;
  logic        [15:0] grant_sec;

  // handshake state shadow
  phase_t      phase;
  logic [7:0]  peer;
  logic [15:0] items_due;
  logic        mission_good;
  logic [15:0] bad_seq;
  logic [31:0] auth_left;
  logic [31:0] hb_left;

  function automatic void model_reset();
    own_id       = 8'd10;
    arm_code     = 16'd3001;
    alt_limit    = 32'sd15000;
    auth_ticks   = 32'd10000;
    hb_ticks     = 32'd3000;
    grant_sec    = 16'd60;
    phase        = PH_IDLE;
    peer         = '0;
    items_due    = '0;
    mission_good = 1'b0;
    bad_seq      = '0;
    auth_left    = '0;
    hb_left      = '0;  // first tick sends a heartbeat
  endfunction

  function automatic int unsigned draw_wait(pace_t mode);
    case (mode)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 18);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function automatic res_t mk_word(kind_t k, logic [7:0] dest, ack_t a, reason_t r,
                                   logic [15:0] param, logic [15:0] seq);
    res_t w;
    w.kind        = k;
    w.dest_system = dest;
    w.ack_result  = a;
    w.deny_reason = r;
    w.ack_param   = param;
    w.request_seq = seq;
    return w;
  endfunction

  // expected result words of one accepted message word, appended to reply_q
  function automatic void handshake_step(msg_t m);
    res_t        caused[$];
    logic [15:0] next_seq;
    logic        for_us;
    reply_t      r;
    for_us = (m.target == own_id);
    case (m.op)
      OP_CMD: begin
        if (m.code == arm_code && phase == PH_IDLE && for_us) begin
          peer  = m.sender;
          phase = PH_COUNT;
          caused.push_back(mk_word(KIND_CMD_ACK, peer, ACK_IN_PROGRESS, REASON_NONE, 0, 0));
          caused.push_back(mk_word(KIND_LIST_REQ, peer, ACK_IN_PROGRESS, REASON_NONE, 0, 0));
          auth_left = auth_ticks;
        end
      end
      OP_COUNT: begin
        if (phase == PH_COUNT && for_us) begin
          if (m.count == 16'd0) begin
            // empty mission is denied at once
            caused.push_back(mk_word(KIND_CMD_ACK, peer, ACK_DENIED, REASON_BAD_ITEM, 0, 0));
            phase = PH_IDLE;
          end else begin
            items_due    = m.count;
            phase        = PH_ITEMS;
            mission_good = 1'b1;
            caused.push_back(mk_word(KIND_ITEM_REQ, peer, ACK_IN_PROGRESS, REASON_NONE, 0, 0));
          end
        end
      end
      OP_ITEM: begin
        if (phase == PH_ITEMS && for_us) begin
          // only the first item above the limit is kept
          if (mission_good && m.alt > alt_limit) begin
            mission_good = 1'b0;
            bad_seq      = m.seq;
          end
          next_seq = m.seq + 16'd1;
          if (next_seq == items_due) begin
            if (mission_good)
              caused.push_back(mk_word(KIND_CMD_ACK, peer, ACK_ACCEPTED, REASON_NONE,
                                       grant_sec, 0));
            else
              caused.push_back(mk_word(KIND_CMD_ACK, peer, ACK_DENIED, REASON_BAD_ITEM,
                                       bad_seq, 0));
            caused.push_back(mk_word(KIND_MISSION_ACK, peer, ACK_IN_PROGRESS, REASON_NONE,
                                     0, 0));
            phase = PH_IDLE;
          end else begin
            caused.push_back(mk_word(KIND_ITEM_REQ, peer, ACK_IN_PROGRESS, REASON_NONE,
                                     0, next_seq));
          end
        end
      end
      default: begin
        if (hb_left == 32'd0) begin
          caused.push_back(mk_word(KIND_HEARTBEAT, 8'd0, ACK_IN_PROGRESS, REASON_NONE, 0, 0));
          hb_left = (hb_ticks != 32'd0) ? hb_ticks - 32'd1 : 32'd0;
        end else begin
          hb_left = hb_left - 32'd1;
        end
        if (phase != PH_IDLE) begin
          if (auth_left == 32'd0) begin
            caused.push_back(mk_word(KIND_CMD_ACK, peer, ACK_FAILED, REASON_TIMEOUT, 0, 0));
            caused.push_back(mk_word(KIND_MISSION_ACK, peer, ACK_IN_PROGRESS, REASON_NONE,
                                     0, 0));
            phase = PH_IDLE;
          end else begin
            auth_left = auth_left - 32'd1;
          end
        end
      end
    endcase
    foreach (caused[i]) begin
      r.w    = caused[i];
      r.last = (i == caused.size() - 1);
      reply_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void send(op_t op, logic [7:0] sender, logic [7:0] target,
                               logic [15:0] code, logic [15:0] count, logic [15:0] seq,
                               logic [31:0] alt);
    msg_t m;
    m.op     = op;
    m.sender = sender;
    m.target = target;
    m.code   = code;
    m.count  = count;
    m.seq    = seq;
    m.alt    = alt;
    msg_q.push_back(m);
    n_queued++;
  endfunction

  // fully random word, mostly ignored by the block
  function automatic void add_noise();
    send(op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom), $urandom);
    n_noise++;
  endfunction

  function automatic void add_tick();
    send(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), $urandom);
  endfunction

  function automatic logic [31:0] pick_alt();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return alt_limit;
      2:       return alt_limit + 32'sd1;
      3:       return alt_limit - $urandom_range(0, 1000);
      4:       return $urandom_range(0, 30000);
      default: return 32'd0 - $urandom_range(0, 30000);
    endcase
  endfunction

  // one arm handshake with random content; a broken one stops early or
  // carries stray sequence numbers
  function automatic void add_session(bit broken);
    logic [15:0] cnt;
    logic [15:0] first;
    logic [15:0] seq;
    int unsigned n;
    int unsigned cut;
    int unsigned i;
    logic [7:0]  who;
    who = 8'($urandom_range(0, 255));
    send(OP_CMD, who, own_id, arm_code, 16'($urandom), 16'($urandom), $urandom);
    if ($urandom_range(0, 3) == 0) add_tick();
    if ($urandom_range(0, 9) == 0) cnt = 16'd0;
    else if ($urandom_range(0, 7) == 0) cnt = 16'($urandom_range(6, 65535));
    else cnt = 16'($urandom_range(1, 5));
    // long missions: only the tail items are sent, numbered near the count
    n     = (cnt > 16'd5) ? $urandom_range(1, 3) : 32'(cnt);
    first = cnt - 16'(n);
    cut   = broken ? $urandom_range(0, n) : n;
    send(OP_COUNT, 8'($urandom), own_id, 16'($urandom), cnt, 16'($urandom), $urandom);
    for (i = 0; i < cut; i++) begin
      seq = first + 16'(i);
      if (broken && $urandom_range(0, 3) == 0) seq = 16'($urandom);
      send(OP_ITEM, 8'($urandom), own_id, 16'($urandom), 16'($urandom), seq, pick_alt());
      if ($urandom_range(0, 3) == 0) add_tick();
      if ($urandom_range(0, 7) == 0) add_noise();
    end
  endfunction

  function automatic void add_random(int unsigned n, bit allow_broken);
    int unsigned base;
    int unsigned pick;
    base = n_queued - n_noise;
    while (n_queued - n_noise - base < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) add_session(1'b0);
      else if (pick == 7) add_noise();
      else if (pick == 8) repeat ($urandom_range(1, 4)) add_tick();
      else add_session(allow_broken);
    end
  endfunction

  // waits until every word is taken and answered, then lets the block settle
  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || reply_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_OWN_ID:       own_id     = val[7:0];
      REG_ARM_CMD:      arm_code   = val[15:0];
      REG_MAX_ALT:      alt_limit  = val;
      REG_AUTH_TIMEOUT: auth_ticks = val;
      REG_HB_PERIOD:    hb_ticks   = val;
      REG_GRANT_SEC:    grant_sec  = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [7:0] id, logic [15:0] code, logic [31:0] alt,
                          logic [31:0] timeout, logic [31:0] period, logic [15:0] grant);
    write_reg(REG_OWN_ID, 32'(id));
    write_reg(REG_ARM_CMD, 32'(code));
    write_reg(REG_MAX_ALT, alt);
    write_reg(REG_AUTH_TIMEOUT, timeout);
    write_reg(REG_HB_PERIOD, period);
    write_reg(REG_GRANT_SEC, 32'(grant));
  endtask

  // ----------------------------------------------------------------- driver
  // a word is held until taken, then the sender may idle before the next one
  always @(negedge clk) begin : drive_words
    msg_t m;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fired) begin
      if (in_if.valid) in_gap = draw_wait(in_mode);
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (msg_q.size() > 0) begin
        m = msg_q.pop_front();
        in_if.op               <= m.op;
        in_if.sender_system    <= m.sender;
        in_if.addressed_system <= m.target;
        in_if.command_code     <= m.code;
        in_if.item_count       <= m.count;
        in_if.item_seq         <= m.seq;
        in_if.altitude_mm      <= m.alt;
        in_if.valid            <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stalls for a drawn number of cycles after each result word
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_fired) out_stall = draw_wait(out_mode);
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // prediction and checking share one block, so a word taken at an edge is
  // modeled before any of its results can show up on out_ch
  always @(posedge clk) begin : watch_words
    msg_t   seen;
    reply_t want;
    if (!rst_n) begin
      in_fired  <= 1'b0;
      out_fired <= 1'b0;
    end else begin
      in_fired  <= in_if.valid && in_if.ready;
      out_fired <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen.op     = op_t'(in_if.op);
        seen.sender = in_if.sender_system;
        seen.target = in_if.addressed_system;
        seen.code   = in_if.command_code;
        seen.count  = in_if.item_count;
        seen.seq    = in_if.item_seq;
        seen.alt    = in_if.altitude_mm;
        n_taken++;
        handshake_step(seen);
      end
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          $error("result word with none expected: kind %0d dest %0d", out_if.kind,
                 out_if.dest_system);
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("kind", want.w.kind, out_if.kind);
          check_field("dest_system", want.w.dest_system, out_if.dest_system);
          check_field("ack_result", want.w.ack_result, out_if.ack_result);
          check_field("deny_reason", want.w.deny_reason, out_if.deny_reason);
          check_field("ack_param", want.w.ack_param, out_if.ack_param);
          check_field("request_seq", want.w.request_seq, out_if.request_seq);
          check_field("last", want.last, out_if.last);
        end
      end
    end
  end

  // ------------------------------------------------------------------- flow
  initial begin
    in_if.valid            = 1'b0;
    in_if.op               = OP_CMD;
    in_if.sender_system    = '0;
    in_if.addressed_system = '0;
    in_if.command_code     = '0;
    in_if.item_count       = '0;
    in_if.item_seq         = '0;
    in_if.altitude_mm      = '0;
    out_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_OWN_ID;
    cfg_if.data            = '0;
    model_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register values after reset; words that must be ignored first
    send(OP_CMD, 8'd1, own_id + 8'd1, arm_code, 0, 0, 0);      // other system
    send(OP_CMD, 8'd1, own_id, arm_code - 16'd1, 0, 0, 0);     // other command
    send(OP_COUNT, 8'd1, own_id, 0, 16'd4, 0, 0);              // count while idle
    send(OP_ITEM, 8'd1, own_id, 0, 0, 0, 0);                   // item while idle
    send(OP_CMD, 8'd255, own_id, arm_code, 0, 0, 0);
    send(OP_CMD, 8'd255, own_id, arm_code, 0, 0, 0);           // repeated arm, busy
    send(OP_COUNT, 8'd255, own_id - 8'd1, 0, 16'd2, 0, 0);     // count for other system
    send(OP_COUNT, 8'd255, own_id, 0, 16'd0, 0, 0);            // empty mission, denied
    // altitude at the limit passes, the one above it is the first bad item
    send(OP_CMD, 8'd0, own_id, arm_code, 0, 0, 0);
    send(OP_COUNT, 8'd0, own_id, 0, 16'd3, 0, 0);
    send(OP_ITEM, 8'd0, own_id + 8'd1, 0, 0, 16'd0, 0);        // item for other system
    send(OP_ITEM, 8'd0, own_id, 0, 0, 16'd0, alt_limit);
    send(OP_ITEM, 8'd0, own_id, 0, 0, 16'd1, 32'h8000_0000);
    send(OP_ITEM, 8'd0, own_id, 0, 0, 16'd2, 32'h7fff_ffff);
    // largest count, sequence wrap, later bad item not remembered
    send(OP_CMD, 8'd7, own_id, arm_code, 0, 0, 0);
    send(OP_COUNT, 8'd7, own_id, 0, 16'hffff, 0, 0);
    send(OP_ITEM, 8'd7, own_id, 0, 0, 16'hffff, alt_limit + 32'sd1);
    send(OP_ITEM, 8'd7, own_id, 0, 0, 16'hfffe, 32'd20000);
    // clean single item mission is granted
    send(OP_CMD, 8'd128, own_id, arm_code, 0, 0, 0);
    send(OP_COUNT, 8'd128, own_id, 0, 16'd1, 0, 0);
    send(OP_ITEM, 8'd128, own_id, 0, 0, 16'd0, 32'd0);
    drain();

    // shortest timeout and heartbeat period: the second tick gives three words
    write_reg(REG_AUTH_TIMEOUT, 32'd1);
    write_reg(REG_HB_PERIOD, 32'd1);
    send(OP_CMD, 8'd3, own_id, arm_code, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 0, 0, 0);
    drain();

    // random handshakes, short timeouts, both sides idling on every word
    in_mode  = PACE_FULL;
    out_mode = PACE_FULL;
    set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
             $urandom_range(0, 40000), $urandom_range(8, 40), $urandom_range(1, 9),
             16'($urandom_range(0, 65535)));
    add_random(55, 1'b1);
    drain();

    // upper extremes at full rate; no broken sessions since nothing times out
    in_mode  = PACE_NONE;
    out_mode = PACE_NONE;
    set_regs(8'd255, 16'hffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    add_random(55, 1'b0);
    drain();

    // lower extremes: every altitude but the smallest is bad, frequent timeouts
    in_mode  = PACE_SPARSE;
    out_mode = PACE_FULL;
    set_regs(8'd0, 16'd0, 32'h8000_0000, 32'd3, 32'd2, 16'd0);
    add_random(55, 1'b1);
    drain();

    // any limit at all, heartbeat on every tick
    in_mode  = PACE_FULL;
    out_mode = PACE_SPARSE;
    set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), $urandom,
             $urandom_range(5, 30), 32'd1, 16'($urandom_range(0, 65535)));
    add_random(55, 1'b1);
    drain();

    if (errors == 0 && reply_q.size() == 0)
      $display("arm_authorization_handshake_unit_tb: PASS");
    else
      $display("arm_authorization_handshake_unit_tb: FAIL");
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("arm_authorization_handshake_unit_tb: FAIL");
    $finish;
  end

endmodule
